FILE: hw/rtl/i2ctb_pkg.sv
// Shared types and codes for the I2C target bit state machine.
// No dependencies; imported by every module of the block.
package i2ctb_pkg;

   localparam int PhaseW = 4;
   localparam int CountW = 4;

   localparam logic [PhaseW-1:0] PH_IDLE      = 4'd0;
   localparam logic [PhaseW-1:0] PH_ADDR      = 4'd1;
   localparam logic [PhaseW-1:0] PH_ADDR_ACK  = 4'd2;
   localparam logic [PhaseW-1:0] PH_RD_FETCH  = 4'd3;
   localparam logic [PhaseW-1:0] PH_RD_BIT    = 4'd4;
   localparam logic [PhaseW-1:0] PH_RD_ACK    = 4'd5;
   localparam logic [PhaseW-1:0] PH_WR_SETUP  = 4'd6;
   localparam logic [PhaseW-1:0] PH_WR_BIT    = 4'd7;
   localparam logic [PhaseW-1:0] PH_WR_ACK    = 4'd8;
   localparam logic [PhaseW-1:0] PH_WAIT_STOP = 4'd9;

   localparam logic [1:0] NOTE_NONE  = 2'd0;
   localparam logic [1:0] NOTE_STOP  = 2'd1;
   localparam logic [1:0] NOTE_READ  = 2'd2;
   localparam logic [1:0] NOTE_WRITE = 2'd3;

   localparam logic [1:0] CSR_MATCH_A_VALUE = 2'd0;
   localparam logic [1:0] CSR_MATCH_A_MASK  = 2'd1;
   localparam logic [1:0] CSR_MATCH_B_VALUE = 2'd2;
   localparam logic [1:0] CSR_MATCH_B_MASK  = 2'd3;

   localparam logic [CountW-1:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic [PhaseW-1:0] phase;
      logic [7:0]        addr_shift;
      logic [CountW-1:0] bit_count;
      logic [7:0]        data_shift;
      logic              last_byte_flag;
      logic              clock_wants_rise;
      logic              data_events_on;
      logic              data_rise_armed;
      logic              pull_low;
   } state_type;

   typedef struct packed {
      logic [7:0] a_value;
      logic [7:0] a_mask;
      logic [7:0] b_value;
      logic [7:0] b_mask;
   } match_cfg_type;

   typedef struct packed {
      logic       sda_pull_low;
      logic [1:0] notice;
      logic [7:0] target_addr;
      logic [7:0] written_byte;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:            PH_IDLE,
      addr_shift:       8'h00,
      bit_count:        '0,
      data_shift:       8'h00,
      last_byte_flag:   1'b0,
      clock_wants_rise: 1'b0,
      data_events_on:   1'b1,
      data_rise_armed:  1'b0,
      pull_low:         1'b0
   };

   localparam match_cfg_type MATCH_CFG_RESET = '{
      a_value: 8'ha0,
      a_mask:  8'hf8,
      b_value: 8'h82,
      b_mask:  8'hfe
   };

endpackage

FILE: hw/rtl/i2ctb_step.sv
// Next-state and result logic for one pin-edge event.
// Depends on i2ctb_pkg for state, configuration and result types.
module i2ctb_step
   import i2ctb_pkg::*;
(
   input  state_type     cur,
   input  match_cfg_type cfg,
   input  logic          event_pin,
   input  logic          sda_level,
   input  logic          scl_level,
   input  logic [7:0]    read_byte,
   input  logic          read_is_last,
   output state_type     nxt,
   output result_type    res
);

   logic [7:0]        addr_or;
   logic [7:0]        data_or;
   logic [CountW-1:0] count_inc;
   logic              addr_hit;
   logic [1:0]        note;
   logic [7:0]        wbyte;

   assign addr_or   = cur.addr_shift | {7'd0, sda_level};
   assign data_or   = cur.data_shift | {7'd0, sda_level};
   assign count_inc = cur.bit_count + CountW'(1);
   assign addr_hit  = ((addr_or & cfg.a_mask) == cfg.a_value) ||
                      ((addr_or & cfg.b_mask) == cfg.b_value);

   always_comb begin
      nxt   = cur;
      note  = NOTE_NONE;
      wbyte = 8'h00;
      if (event_pin) begin
         if (cur.data_events_on && (!sda_level || cur.data_rise_armed)) begin
            if (sda_level && scl_level) begin
               nxt.phase           = PH_IDLE;
               nxt.data_rise_armed = 1'b0;
               note                = NOTE_STOP;
            end else if (!sda_level && scl_level &&
                         (cur.phase == PH_IDLE || cur.phase == PH_WR_BIT)) begin
               nxt.clock_wants_rise = 1'b1;
               nxt.data_rise_armed  = 1'b1;
               nxt.bit_count        = '0;
               nxt.addr_shift       = 8'h00;
               nxt.phase            = PH_ADDR;
            end
         end
      end else if (scl_level == cur.clock_wants_rise) begin
         unique case (cur.phase)
            PH_ADDR: begin
               nxt.bit_count = count_inc;
               if (count_inc == BITS_PER_BYTE) begin
                  nxt.addr_shift = addr_or;
                  if (addr_hit) begin
                     nxt.phase            = PH_ADDR_ACK;
                     nxt.clock_wants_rise = 1'b0;
                  end else begin
                     nxt.phase = PH_WAIT_STOP;
                  end
               end else begin
                  nxt.addr_shift = {addr_or[6:0], 1'b0};
               end
            end
            PH_ADDR_ACK: begin
               nxt.pull_low = 1'b1;
               nxt.phase    = cur.addr_shift[0] ? PH_RD_FETCH : PH_WR_SETUP;
            end
            PH_RD_FETCH: begin
               // load the byte and drive its first bit at once
               nxt.last_byte_flag = read_is_last;
               nxt.data_events_on = 1'b0;
               nxt.pull_low       = !read_byte[7];
               nxt.bit_count      = CountW'(1);
               nxt.data_shift     = {read_byte[6:0], 1'b0};
               nxt.phase          = PH_RD_BIT;
               note               = NOTE_READ;
            end
            PH_RD_BIT: begin
               nxt.pull_low   = !cur.data_shift[7];
               nxt.bit_count  = count_inc;
               nxt.data_shift = {cur.data_shift[6:0], 1'b0};
               if (count_inc == BITS_PER_BYTE) begin
                  nxt.phase = PH_RD_ACK;
               end
            end
            PH_RD_ACK: begin
               nxt.pull_low = 1'b0;
               if (cur.last_byte_flag) begin
                  nxt.data_events_on = 1'b1;
                  nxt.phase          = PH_WAIT_STOP;
               end else begin
                  nxt.phase = PH_RD_FETCH;
               end
            end
            PH_WR_SETUP: begin
               nxt.pull_low         = 1'b0;
               nxt.clock_wants_rise = 1'b1;
               nxt.phase            = PH_WR_BIT;
               nxt.bit_count        = '0;
               nxt.data_shift       = 8'h00;
            end
            PH_WR_BIT: begin
               nxt.bit_count = count_inc;
               if (count_inc == BITS_PER_BYTE) begin
                  nxt.data_shift       = data_or;
                  nxt.phase            = PH_WR_ACK;
                  nxt.clock_wants_rise = 1'b0;
               end else begin
                  nxt.data_shift = {data_or[6:0], 1'b0};
               end
            end
            PH_WR_ACK: begin
               nxt.pull_low = 1'b1;
               nxt.phase    = PH_WR_SETUP;
               note         = NOTE_WRITE;
               wbyte        = cur.data_shift;
            end
            default: begin
               // idle, waiting for stop and unused codes: hold
            end
         endcase
      end
   end

   assign res.sda_pull_low = nxt.pull_low;
   assign res.notice       = note;
   assign res.target_addr  = nxt.addr_shift;
   assign res.written_byte = wbyte;

endmodule

FILE: hw/rtl/i2ctb_out_reg.sv
// Result register of the response channel with valid/ready handshake.
// Depends on i2ctb_pkg for the result type.
module i2ctb_out_reg
   import i2ctb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output logic       can_load,
   output result_type rsp_data
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // accept a new beat when empty or when the held one leaves this cycle
   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: hw/rtl/i2c_target_bit_fsm.sv
// Top level of the I2C target bit state machine: state, match registers
// and the result register. Depends on i2ctb_pkg, i2ctb_step, i2ctb_out_reg.
//
// Usage: each req_ beat is one edge on the clock or data line (req_event_pin
// 0 or 1) with the sampled levels, plus the byte to send should a read byte
// be fetched. Every request beat yields exactly one rsp_ beat carrying the
// data-line driver state, a notice code, the address byte so far and the
// byte just written by the controller.
// The response is registered and appears in the cycle after the request is taken.
// Throughput: one event per cycle when not stalled; the state update is a single pass of
// logic from the state registers into themselves and the result register.
// Stall: while rsp_valid is high and rsp_ready low, req_ready drops and the
// held response stays unchanged; req_ready rises again in the cycle the
// response is taken.
// Reset: synchronous, active high; the machine returns to idle with the
// driver released and the match registers at their default values.
// csr_ writes take effect in the following cycle; write only when idle.
module i2c_target_bit_fsm
   import i2ctb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_event_pin,
   input  logic       req_sda_level,
   input  logic       req_scl_level,
   input  logic [7:0] req_read_byte,
   input  logic       req_read_is_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_sda_pull_low,
   output logic [1:0] rsp_notice,
   output logic [7:0] rsp_target_addr,
   output logic [7:0] rsp_written_byte,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   state_type     state_ff;
   state_type     state_in;
   match_cfg_type cfg_ff;
   match_cfg_type cfg_in;
   result_type    step_res;
   result_type    rsp_data;
   logic          req_beat;

   assign req_beat = req_valid && req_ready;

   i2ctb_step u_step (
      .cur          (state_ff),
      .cfg          (cfg_ff),
      .event_pin    (req_event_pin),
      .sda_level    (req_sda_level),
      .scl_level    (req_scl_level),
      .read_byte    (req_read_byte),
      .read_is_last (req_read_is_last),
      .nxt          (state_in),
      .res          (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (req_beat) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MATCH_A_VALUE: cfg_in.a_value = csr_wdata;
            CSR_MATCH_A_MASK:  cfg_in.a_mask  = csr_wdata;
            CSR_MATCH_B_VALUE: cfg_in.b_value = csr_wdata;
            CSR_MATCH_B_MASK:  cfg_in.b_mask  = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= MATCH_CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   i2ctb_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (req_beat),
      .load_data (step_res),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .can_load  (req_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_sda_pull_low = rsp_data.sda_pull_low;
   assign rsp_notice       = rsp_data.notice;
   assign rsp_target_addr  = rsp_data.target_addr;
   assign rsp_written_byte = rsp_data.written_byte;

endmodule
